// File: rtl/tfbbp_pkg.sv
// ----------------------------------------------------------------------------
// tfbbp_pkg
// Types and constants for the temporary file block buffer policy unit:
// address split, buffer and status codes, request and result transactions.
// ----------------------------------------------------------------------------
package tfbbp_pkg;

	// Address split and block geometry
	localparam int OFFSET_BITS      = 6;
	localparam int GRAIN_SHIFT      = 3;
	localparam int BLOCK_INDEX_BITS = 10;
	localparam int BLOCK_COUNT      = 1024;
	localparam int BLOCK_BYTES      = 512;

	// Field widths of the transactions
	localparam int ADDR_W   = 16;
	localparam int SEL_W    = 2;
	localparam int OFF_W    = 9;
	localparam int LEFT_W   = 10;
	localparam int BLK_W    = 10;
	localparam int STATUS_W = 2;

	// Width of the shifted grain offset before the block wrap
	localparam int SHIFT_W  = OFFSET_BITS + GRAIN_SHIFT;
	// Block number plus one bit, so the range compare can see BLOCK_COUNT
	localparam int BCMP_W   = BLOCK_INDEX_BITS + 1;

	// Buffer codes
	localparam logic [SEL_W-1:0] BUF_READ_A = 2'd0;
	localparam logic [SEL_W-1:0] BUF_READ_B = 2'd1;
	localparam logic [SEL_W-1:0] BUF_WRITE  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Access type codes
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] line_address;
	} req_t;

	typedef struct packed {
		logic [SEL_W-1:0]    buffer_select;
		logic [OFF_W-1:0]    byte_offset;
		logic [LEFT_W-1:0]   bytes_left;
		logic                writeback_valid;
		logic [BLK_W-1:0]    writeback_block;
		logic [SEL_W-1:0]    writeback_buffer;
		logic                fill_valid;
		logic [BLK_W-1:0]    fill_block;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// File: rtl/tfbbp_policy.sv
// ----------------------------------------------------------------------------
// tfbbp_policy
// Buffer tags, dirty marks and the read victim flag, with the decision logic
// that turns one request into one result. State moves only on advance.
// ----------------------------------------------------------------------------
module tfbbp_policy (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  tfbbp_pkg::req_t req,
	output tfbbp_pkg::rsp_t rsp
);
	import tfbbp_pkg::*;

	// Tag state: a valid bit stands in for the all-ones "no block" tag
	logic [BLK_W-1:0] tag_a_q, tag_b_q, tag_w_q;
	logic             vld_a_q, vld_b_q, vld_w_q;
	logic             dirty_a_q, dirty_b_q;
	logic             use_second_q;

	logic [BLK_W-1:0] tag_a_d, tag_b_d, tag_w_d;
	logic             vld_a_d, vld_b_d, vld_w_d;
	logic             dirty_a_d, dirty_b_d;
	logic             use_second_d;

	logic [BLOCK_INDEX_BITS-1:0] blk;
	logic [SHIFT_W-1:0]          shifted;
	logic [OFF_W-1:0]            off;
	logic [LEFT_W-1:0]           left;
	logic                        is_null, too_large;
	logic                        hit_a, hit_b, hit_w;

	// Address split
	assign blk       = req.line_address[OFFSET_BITS +: BLOCK_INDEX_BITS];
	assign shifted   = {req.line_address[OFFSET_BITS-1:0], {GRAIN_SHIFT{1'b0}}};
	assign off       = OFF_W'(shifted);
	assign left      = LEFT_W'(BLOCK_BYTES) - LEFT_W'(off);
	assign is_null   = (req.line_address == '0);
	assign too_large = ({1'b0, blk} >= BCMP_W'(BLOCK_COUNT));

	// Tag compares
	assign hit_a = vld_a_q && (tag_a_q == BLK_W'(blk));
	assign hit_b = vld_b_q && (tag_b_q == BLK_W'(blk));
	assign hit_w = vld_w_q && (tag_w_q == BLK_W'(blk));

	// Decision and next state
	always_comb begin
		rsp          = '0;
		tag_a_d      = tag_a_q;
		tag_b_d      = tag_b_q;
		tag_w_d      = tag_w_q;
		vld_a_d      = vld_a_q;
		vld_b_d      = vld_b_q;
		vld_w_d      = vld_w_q;
		dirty_a_d    = dirty_a_q;
		dirty_b_d    = dirty_b_q;
		use_second_d = use_second_q;
		if (is_null) begin
			rsp.status = ST_NULL;
		end else if (too_large) begin
			rsp.status = ST_RANGE;
		end else begin
			rsp.status      = ST_OK;
			rsp.byte_offset = off;
			rsp.bytes_left  = left;
			if (hit_a) begin
				rsp.buffer_select = BUF_READ_A;
				if (req.req_type == REQ_WRITE) begin
					dirty_a_d = 1'b1;
				end
			end else if (hit_b) begin
				rsp.buffer_select = BUF_READ_B;
				if (req.req_type == REQ_WRITE) begin
					dirty_b_d = 1'b1;
				end
			end else if (hit_w) begin
				rsp.buffer_select = BUF_WRITE;
			end else if (req.req_type == REQ_READ) begin
				// read miss: alternate the victim, write back if dirty, then fill
				rsp.fill_valid = 1'b1;
				rsp.fill_block = BLK_W'(blk);
				if (!use_second_q) begin
					rsp.buffer_select   = BUF_READ_B;
					rsp.writeback_valid = dirty_b_q;
					if (dirty_b_q) begin
						rsp.writeback_block  = tag_b_q;
						rsp.writeback_buffer = BUF_READ_B;
					end
					dirty_b_d    = 1'b0;
					tag_b_d      = BLK_W'(blk);
					vld_b_d      = 1'b1;
					use_second_d = 1'b1;
				end else begin
					rsp.buffer_select   = BUF_READ_A;
					rsp.writeback_valid = dirty_a_q;
					if (dirty_a_q) begin
						rsp.writeback_block  = tag_a_q;
						rsp.writeback_buffer = BUF_READ_A;
					end
					dirty_a_d    = 1'b0;
					tag_a_d      = BLK_W'(blk);
					vld_a_d      = 1'b1;
					use_second_d = 1'b0;
				end
			end else begin
				// write miss: flush any held write block, allocate without fill
				rsp.buffer_select   = BUF_WRITE;
				rsp.writeback_valid = vld_w_q;
				if (vld_w_q) begin
					rsp.writeback_block  = tag_w_q;
					rsp.writeback_buffer = BUF_WRITE;
				end
				tag_w_d = BLK_W'(blk);
				vld_w_d = 1'b1;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q      <= 1'b0;
			vld_b_q      <= 1'b0;
			vld_w_q      <= 1'b0;
			dirty_a_q    <= 1'b0;
			dirty_b_q    <= 1'b0;
			use_second_q <= 1'b0;
		end else if (advance) begin
			vld_a_q      <= vld_a_d;
			vld_b_q      <= vld_b_d;
			vld_w_q      <= vld_w_d;
			dirty_a_q    <= dirty_a_d;
			dirty_b_q    <= dirty_b_d;
			use_second_q <= use_second_d;
		end
	end

	// Tags, qualified by their valid bits
	always_ff @(posedge clk) begin
		if (advance) begin
			tag_a_q <= tag_a_d;
			tag_b_q <= tag_b_d;
			tag_w_q <= tag_w_d;
		end
	end

endmodule

// File: rtl/temp_file_block_buffer_policy_unit.sv
// ----------------------------------------------------------------------------
// temp_file_block_buffer_policy_unit
// Buffer policy for a line-addressed temporary file: two read buffers and
// one write buffer, reporting hits, write-backs and fills per request.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid, req_stall, req) carries one access request per
//   transaction: read or write and a packed line address.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one result per
//   request, in order.
//   rsp_valid rises once the request has moved from the input register,
//   through the tag compares and state update, into the result register;
//   a stall on the result side can hold it in the input register.
//   One request per cycle is sustained while rsp_stall is low, set by the
//   single pass of three tag compares between the two registers.
//   When rsp_stall is high the result register holds; the input register
//   still takes one more request, after which req_stall rises.
//   Reset clears all buffers to empty, all dirty marks, and makes the next
//   read miss fill the second read buffer. No clearing pass is needed.
// ----------------------------------------------------------------------------
module temp_file_block_buffer_policy_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  tfbbp_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output tfbbp_pkg::rsp_t rsp
);
	import tfbbp_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_next;
	logic advance;

	// Move the held request on when the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	tfbbp_policy u_policy (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.rsp     (rsp_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// An error result carries no write-back and no fill
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> !rsp.writeback_valid && !rsp.fill_valid)
		else $error("error result with write-back or fill");

	// The write buffer is never filled
	a_no_write_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.fill_valid |-> (rsp.buffer_select != BUF_WRITE))
		else $error("fill requested for write buffer");

	// A write buffer flush only comes with a write miss into that buffer
	a_wb_write: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.writeback_valid && (rsp.writeback_buffer == BUF_WRITE)
		|-> (rsp.buffer_select == BUF_WRITE) && !rsp.fill_valid)
		else $error("write buffer flush on wrong path");

	// A held request is not dropped while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("held request lost");
`endif

endmodule

// File: bench/tfbbp_access_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfbbp_access_checker
// Watches the request and result channels of the buffer policy unit. Keeps
// its own copy of the buffer tags, dirty marks and victim flag, works out the
// result of every accepted request and compares each accepted result with the
// oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module tfbbp_access_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  tfbbp_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  tfbbp_pkg::rsp_t rsp,
	output int              fail_count,
	output int              outstanding,
	output int              checked_count,
	output int              hit_count,
	output int              fill_count,
	output int              wb_count,
	output int              null_count
);
	import tfbbp_pkg::*;

	localparam logic [BCMP_W-1:0] NO_TAG = '1;

	// Predicted buffer state
	logic [BCMP_W-1:0] tag_a;
	logic [BCMP_W-1:0] tag_b;
	logic [BCMP_W-1:0] tag_w;
	logic              dirty_a;
	logic              dirty_b;
	logic              victim_first;

	rsp_t expected_rsp_q [$];

	initial begin
		fail_count    = 0;
		outstanding   = 0;
		checked_count = 0;
		hit_count     = 0;
		fill_count    = 0;
		wb_count      = 0;
		null_count    = 0;
	end

	// One line per mismatch, and count it
	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	// Work out the result of one request and update the buffer state
	function automatic rsp_t predict_access(input req_t r);
		rsp_t              res;
		logic [BCMP_W-1:0] blk_cmp;
		logic [BLK_W-1:0]  blk;
		logic [SHIFT_W-1:0] shifted;
		logic [OFF_W-1:0]  off;
		logic              is_write;
		res      = '0;
		is_write = (r.req_type == REQ_WRITE);
		if (r.line_address == '0) begin
			res.status = ST_NULL;
			null_count++;
			return res;
		end
		blk_cmp = BCMP_W'((r.line_address >> OFFSET_BITS) & ((1 << BLOCK_INDEX_BITS) - 1));
		shifted = SHIFT_W'(r.line_address[OFFSET_BITS-1:0]) << GRAIN_SHIFT;
		off     = OFF_W'(shifted % BLOCK_BYTES);
		if (blk_cmp >= BLOCK_COUNT) begin
			res.status = ST_RANGE;
			return res;
		end
		blk             = BLK_W'(blk_cmp);
		res.status      = ST_OK;
		res.byte_offset = off;
		res.bytes_left  = LEFT_W'(BLOCK_BYTES - off);

		// Hits: first read buffer, second read buffer, then write buffer
		if (tag_a != NO_TAG && tag_a == blk_cmp) begin
			if (is_write)
				dirty_a = 1'b1;
			res.buffer_select = BUF_READ_A;
			hit_count++;
		end else if (tag_b != NO_TAG && tag_b == blk_cmp) begin
			if (is_write)
				dirty_b = 1'b1;
			res.buffer_select = BUF_READ_B;
			hit_count++;
		end else if (tag_w != NO_TAG && tag_w == blk_cmp) begin
			res.buffer_select = BUF_WRITE;
			hit_count++;
		end else if (!is_write) begin
			// Read miss: alternate the victim between the read buffers
			res.fill_valid = 1'b1;
			res.fill_block = blk;
			fill_count++;
			if (!victim_first) begin
				res.buffer_select = BUF_READ_B;
				if (dirty_b) begin
					res.writeback_valid  = 1'b1;
					res.writeback_block  = BLK_W'(tag_b);
					res.writeback_buffer = BUF_READ_B;
				end
				dirty_b      = 1'b0;
				tag_b        = blk_cmp;
				victim_first = 1'b1;
			end else begin
				res.buffer_select = BUF_READ_A;
				if (dirty_a) begin
					res.writeback_valid  = 1'b1;
					res.writeback_block  = BLK_W'(tag_a);
					res.writeback_buffer = BUF_READ_A;
				end
				dirty_a      = 1'b0;
				tag_a        = blk_cmp;
				victim_first = 1'b0;
			end
		end else begin
			// Write miss: an occupied write buffer is always written back
			res.buffer_select = BUF_WRITE;
			if (tag_w != NO_TAG) begin
				res.writeback_valid  = 1'b1;
				res.writeback_block  = BLK_W'(tag_w);
				res.writeback_buffer = BUF_WRITE;
			end
			tag_w = blk_cmp;
		end
		if (res.writeback_valid)
			wb_count++;
		return res;
	endfunction

	// Predict on request transactions, compare on result transactions
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			tag_a        = NO_TAG;
			tag_b        = NO_TAG;
			tag_w        = NO_TAG;
			dirty_a      = 1'b0;
			dirty_b      = 1'b0;
			victim_first = 1'b0;
			expected_rsp_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("unexpected result, outstanding", 1, 0);
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					checked_count++;
					if (rsp.buffer_select != exp_rsp.buffer_select)
						report_mismatch("buffer_select", rsp.buffer_select,
							exp_rsp.buffer_select);
					if (rsp.byte_offset != exp_rsp.byte_offset)
						report_mismatch("byte_offset", rsp.byte_offset, exp_rsp.byte_offset);
					if (rsp.bytes_left != exp_rsp.bytes_left)
						report_mismatch("bytes_left", rsp.bytes_left, exp_rsp.bytes_left);
					if (rsp.writeback_valid != exp_rsp.writeback_valid)
						report_mismatch("writeback_valid", rsp.writeback_valid,
							exp_rsp.writeback_valid);
					if (rsp.writeback_block != exp_rsp.writeback_block)
						report_mismatch("writeback_block", rsp.writeback_block,
							exp_rsp.writeback_block);
					if (rsp.writeback_buffer != exp_rsp.writeback_buffer)
						report_mismatch("writeback_buffer", rsp.writeback_buffer,
							exp_rsp.writeback_buffer);
					if (rsp.fill_valid != exp_rsp.fill_valid)
						report_mismatch("fill_valid", rsp.fill_valid, exp_rsp.fill_valid);
					if (rsp.fill_block != exp_rsp.fill_block)
						report_mismatch("fill_block", rsp.fill_block, exp_rsp.fill_block);
					if (rsp.status != exp_rsp.status)
						report_mismatch("status", rsp.status, exp_rsp.status);
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(predict_access(req));
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

// File: bench/tb_temp_file_block_buffer_policy_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temp_file_block_buffer_policy_unit
// Drives access requests into the buffer policy unit: a directed walk through
// hits, read and write misses, dirty write-backs and null addresses, then
// random requests over a small working set of blocks with random idling on
// both channels. Checking is done by the access checker beside the unit.
// ----------------------------------------------------------------------------
module tb_temp_file_block_buffer_policy_unit;
	import tfbbp_pkg::*;

	localparam int RANDOM_ITEMS   = 1600;
	localparam int POOL_SIZE      = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic no_idle     = 1'b0;
	int   stall_left  = 0;
	int   idle_cycles = 0;
	int   sent_count  = 0;
	int   directed_count;

	int fail_count;
	int outstanding;
	int checked_count;
	int hit_count;
	int fill_count;
	int wb_count;
	int null_count;

	temp_file_block_buffer_policy_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	tfbbp_access_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.checked_count (checked_count),
		.hit_count     (hit_count),
		.fill_count    (fill_count),
		.wb_count      (wb_count),
		.null_count    (null_count)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: stall for a random number of cycles after each transaction
	always @(posedge clk) begin
		int hold;
		if (rsp_valid && !rsp_stall) begin
			hold = no_idle ? 0 : $urandom_range(0, 13);
			stall_left <= hold;
			rsp_stall  <= (hold != 0);
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= 0;
			rsp_stall  <= 1'b0;
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Present one request after a random gap and hold it until accepted
	task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid         <= 1'b1;
		req.req_type      <= kind;
		req.line_address  <= addr;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent_count++;
	endtask

	// Stop sending until every predicted result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [BLK_W-1:0]  pool [POOL_SIZE];
		logic [ADDR_W-1:0] addr;
		int                pick;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the policy
		send_access(REQ_READ,  16'h0000);   // null address
		send_access(REQ_WRITE, 16'h0000);   // null address, write
		send_access(REQ_READ,  16'h0001);   // block 0 miss, fills second buffer
		send_access(REQ_READ,  16'h0041);   // block 1 miss, fills first buffer
		send_access(REQ_WRITE, 16'h0002);   // write hit, second buffer dirty
		send_access(REQ_WRITE, 16'h0043);   // write hit, first buffer dirty
		send_access(REQ_READ,  16'hFFFF);   // top block, dirty victim written back
		send_access(REQ_READ,  16'h0080);   // dirty first buffer written back
		send_access(REQ_WRITE, 16'h00C0);   // write miss, write buffer empty
		send_access(REQ_WRITE, 16'h0100);   // write miss, old write block out
		send_access(REQ_WRITE, 16'h013F);   // write hit, top offset
		send_access(REQ_READ,  16'h0105);   // read hit in the write buffer
		send_access(REQ_READ,  16'hFFC0);   // read hit, offset zero
		send_access(REQ_READ,  16'h003F);   // clean victim, no write-back
		send_access(REQ_WRITE, 16'h0000);   // null address with buffers full
		send_access(REQ_WRITE, 16'hFFFF);   // write miss, top block
		send_access(REQ_WRITE, 16'hFFFE);   // write hit in the write buffer
		send_access(REQ_READ,  16'h0040);   // read miss, clean first buffer refilled
		directed_count = sent_count;
		wait_drained();

		// Random requests, mostly over a small working set of blocks
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) begin
				foreach (pool[k])
					pool[k] = BLK_W'($urandom_range(0, BLOCK_COUNT - 1));
				if ($urandom_range(0, 1) == 0)
					pool[0] = '0;
				else
					pool[0] = '1;
			end
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 5)
				addr = '0;
			else if (pick < 75)
				addr = {pool[$urandom_range(0, POOL_SIZE - 1)],
					OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1))};
			else
				addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
			send_access(logic'($urandom_range(0, 1)), addr);
		end

		// Drain and let the pipeline settle
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed), checked %0d results",
			sent_count, directed_count, checked_count);
		$display("Hits %0d, fills %0d, write-backs %0d, null addresses %0d",
			hit_count, fill_count, wb_count, null_count);
		if (fail_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
